### hdl/quaternion_vector_rotation_defines.svh
// assertion macros shared by the quaternion rotation block
`ifndef QUATERNION_VECTOR_ROTATION_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATION_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define QVR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QVR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/qvr_pkg.sv
package qvr_pkg;

  localparam int REG_W = 16;
  localparam int VEC_W = 16;
  localparam int NUM_ENTRIES = 9;

  // build counter start value on a quaternion write; busy lasts until the matrix holds the new value
  localparam logic [1:0] BUILD_LAT = 2'd3;

  typedef enum logic [1:0] {
    REG_QUAT_W,
    REG_QUAT_X,
    REG_QUAT_Y,
    REG_QUAT_Z
  } cfg_reg_t;

  typedef struct packed {
    cfg_reg_t             index;
    logic [REG_W-1:0]     value;
  } cfg_wr_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] vec_x;
    logic signed [VEC_W-1:0] vec_y;
    logic signed [VEC_W-1:0] vec_z;
  } vec_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] rot_x;
    logic signed [VEC_W-1:0] rot_y;
    logic signed [VEC_W-1:0] rot_z;
    logic                    clipped;
  } rot_t;

endpackage

### hdl/qvr_stream_if.sv
interface qvr_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/quaternion_vector_rotation.sv
// Rotates a stream of signed 16-bit 3-D vectors by the matrix of a quaternion (w,x,y,z)
// in signed Q1.15 (QUAT_FRAC_BITS fraction bits) written through the cfg channel at
// indexes 0..3. Each vector is multiplied by the column-major matrix, rounded half up
// to an integer and saturated to 16 bits; clipped flags any saturated component.
// One vector is taken per clock while there is no output stall, rebuild or cfg write;
// a result passes the multiply, sum and round/saturate stages, and bubbles are squeezed
// out under output stall. After reset and after every quaternion write the matrix is
// rebuilt through its own multiply/add/round pipeline, and vec.ready stays low during
// the rebuild. cfg.ready is always high.
`include "quaternion_vector_rotation_defines.svh"

module quaternion_vector_rotation
  import qvr_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = 15
) (
  input  logic         clk,
  input  logic         rst,
  qvr_stream_if.sink   cfg,
  qvr_stream_if.sink   vec,
  qvr_stream_if.source rot
);

  localparam int F  = QUAT_FRAC_BITS;
  localparam int MW = F + 3;
  localparam int PW = MW + VEC_W;
  localparam int SW = PW + 2;

  localparam logic signed [SW-1:0] HALF_S = {{(SW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [SW-1:0] O_HI   = {{(SW-VEC_W+1){1'b0}}, {(VEC_W-1){1'b1}}};
  localparam logic signed [SW-1:0] O_LO   = {{(SW-VEC_W+1){1'b1}}, {(VEC_W-1){1'b0}}};

  logic [NUM_ENTRIES-1:0][MW-1:0] mat;
  logic                           mbusy;

  logic                    v0, v1, v2;
  logic                    en0, en1, en2;
  logic signed [VEC_W-1:0] vin [3];
  logic signed [PW-1:0]    prod [3][3];
  logic signed [SW-1:0]    acc [3];
  logic signed [SW-1:0]    sh [3];
  logic signed [VEC_W-1:0] sat_v [3];
  logic [2:0]              clip_v;
  rot_t                    res;

  qvr_matrix #(
    .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
  ) u_matrix (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .mat (mat),
    .busy(mbusy)
  );

  // each stage advances when empty or when the next one advances
  assign en2       = !v2 || rot.ready;
  assign en1       = !v1 || en2;
  assign en0       = !v0 || en1;
  assign vec.ready = en0 && !mbusy && !cfg.valid;

  assign rot.valid = v2;
  assign rot.data  = res;

  always_comb begin
    vin[0] = vec.data.vec_x;
    vin[1] = vec.data.vec_y;
    vin[2] = vec.data.vec_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en0) begin
        v0 <= vec.valid && vec.ready;
      end
      if (en1) begin
        v1 <= v0;
      end
      if (en2) begin
        v2 <= v1;
      end
    end
  end

  // stage 0: the nine products, row r column c
  always_ff @(posedge clk) begin
    if (en0) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= PW'($signed(mat[3*c+r])) * PW'(vin[c]);
        end
      end
    end
  end

  // stage 1: row sums with the rounding half
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int r = 0; r < 3; r++) begin
        acc[r] <= SW'(prod[r][0]) + SW'(prod[r][1]) + SW'(prod[r][2]) + HALF_S;
      end
    end
  end

  // stage 2: floor to integer and saturate
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sh[r] = acc[r] >>> F;
      if (sh[r] > O_HI) begin
        sat_v[r]  = O_HI[VEC_W-1:0];
        clip_v[r] = 1'b1;
      end else if (sh[r] < O_LO) begin
        sat_v[r]  = O_LO[VEC_W-1:0];
        clip_v[r] = 1'b1;
      end else begin
        sat_v[r]  = sh[r][VEC_W-1:0];
        clip_v[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      res.rot_x   <= sat_v[0];
      res.rot_y   <= sat_v[1];
      res.rot_z   <= sat_v[2];
      res.clipped <= |clip_v;
    end
  end

  `QVR_ASSERT_IMPL(a_accept_settled, vec.valid && vec.ready, !mbusy, "vector taken during rebuild")
  `QVR_ASSERT_NEXT(a_stage0_holds, v0 && !en0, v0, "stalled item lost in stage 0")
  `QVR_ASSERT_NEXT(a_stage1_moves, v1 && en2, v2, "item lost between sum and output")
  `QVR_ASSERT_IMPL(a_clip_at_rail, rot.valid && rot.data.clipped, (rot.data.rot_x == 16'sh7fff) || (rot.data.rot_x == 16'sh8000) || (rot.data.rot_y == 16'sh7fff) || (rot.data.rot_y == 16'sh8000) || (rot.data.rot_z == 16'sh7fff) || (rot.data.rot_z == 16'sh8000), "clipped set with no rail value")

endmodule

### hdl/qvr_matrix.sv
`include "quaternion_vector_rotation_defines.svh"

module qvr_matrix
  import qvr_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = 15
) (
  input  logic                                    clk,
  input  logic                                    rst,
  qvr_stream_if.sink                              cfg,
  output logic [NUM_ENTRIES-1:0][QUAT_FRAC_BITS+2:0] mat,
  output logic                                    busy
);

  localparam int F   = QUAT_FRAC_BITS;
  localparam int MW  = F + 3;
  localparam int EXW = ((2 * F > 34) ? 2 * F : 34) + 2;
  localparam int PW  = 2 * REG_W;

  localparam logic signed [EXW-1:0] ONE  = {{(EXW-2*F-1){1'b0}}, 1'b1, {(2*F){1'b0}}};
  localparam logic signed [EXW-1:0] HALF = {{(EXW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [EXW-1:0] M_HI = {{(EXW-MW+1){1'b0}}, {(MW-1){1'b1}}};
  localparam logic signed [EXW-1:0] M_LO = {{(EXW-MW+1){1'b1}}, {(MW-1){1'b0}}};

  logic signed [REG_W-1:0] qw, qx, qy, qz;
  logic signed [PW-1:0]    pxx, pxy, pxz, pxw, pyy, pyz, pyw, pzz, pzw;
  logic signed [EXW-1:0]   ex [NUM_ENTRIES];
  logic signed [EXW-1:0]   ex_next [NUM_ENTRIES];
  logic [1:0]              bcnt;
  logic                    wr;

  function automatic logic [MW-1:0] sat_entry(input logic signed [EXW-1:0] e);
    logic signed [EXW-1:0] t;
    t = (e + HALF) >>> F;
    if (t > M_HI) begin
      return M_HI[MW-1:0];
    end else if (t < M_LO) begin
      return M_LO[MW-1:0];
    end else begin
      return t[MW-1:0];
    end
  endfunction

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid && cfg.ready;
  assign busy      = (bcnt != 2'd0);

  // quaternion registers and build counter
  always_ff @(posedge clk) begin
    if (rst) begin
      qw   <= 16'sd32767;
      qx   <= '0;
      qy   <= '0;
      qz   <= '0;
      bcnt <= BUILD_LAT;
    end else begin
      if (wr) begin
        unique case (cfg.data.index)
          REG_QUAT_W: qw <= cfg.data.value;
          REG_QUAT_X: qx <= cfg.data.value;
          REG_QUAT_Y: qy <= cfg.data.value;
          REG_QUAT_Z: qz <= cfg.data.value;
        endcase
        bcnt <= BUILD_LAT;
      end else if (bcnt != 2'd0) begin
        bcnt <= bcnt - 2'd1;
      end
    end
  end

  // build pipeline runs every cycle: products, exact entries, rounded entries
  always_ff @(posedge clk) begin
    pxx <= qx * qx;
    pxy <= qx * qy;
    pxz <= qx * qz;
    pxw <= qx * qw;
    pyy <= qy * qy;
    pyz <= qy * qz;
    pyw <= qy * qw;
    pzz <= qz * qz;
    pzw <= qz * qw;
  end

  // column-major: entry 3*c+r is row r of column c
  always_comb begin
    ex_next[0] = ONE - ((EXW'(pyy) + EXW'(pzz)) <<< 1);
    ex_next[1] = (EXW'(pxy) + EXW'(pzw)) <<< 1;
    ex_next[2] = (EXW'(pxz) - EXW'(pyw)) <<< 1;
    ex_next[3] = (EXW'(pxy) - EXW'(pzw)) <<< 1;
    ex_next[4] = ONE - ((EXW'(pxx) + EXW'(pzz)) <<< 1);
    ex_next[5] = (EXW'(pyz) + EXW'(pxw)) <<< 1;
    ex_next[6] = (EXW'(pxz) + EXW'(pyw)) <<< 1;
    ex_next[7] = (EXW'(pyz) - EXW'(pxw)) <<< 1;
    ex_next[8] = ONE - ((EXW'(pxx) + EXW'(pyy)) <<< 1);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      ex[i]  <= ex_next[i];
      mat[i] <= sat_entry(ex[i]);
    end
  end

  `QVR_ASSERT_NEXT(a_write_starts_build, wr, bcnt == BUILD_LAT, "write did not restart build")
  `QVR_ASSERT_NEXT(a_idle_stays_idle, !busy && !wr, !busy, "build started without a write")
  `QVR_ASSERT_NEXT(a_matrix_settled, !busy && !wr, $stable(mat), "matrix moved while settled")

endmodule

### tb/quaternion_vector_rotation_tb.sv
`timescale 1ns / 1ps

module quaternion_vector_rotation_tb
  import qvr_pkg::*;
;
  localparam int FRAC_BITS = 15;
  localparam int RAND_ITEMS = 1400;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 12;

  typedef logic signed [15:0] quat4_t [4];

  // keeps its own quaternion and matrix, and the rotated vectors still owed by the block
  class rotation_board;
    localparam int FRAC = FRAC_BITS;
    localparam int MAT_W = FRAC + 3;

    logic signed [15:0]      quat [4];
    logic signed [MAT_W-1:0] matrix [9];
    rot_t                    expected_rots [$];
    int                      errors;
    int                      checked;
    int                      clipped_seen;

    function new();
      quat[REG_QUAT_W] = 16'sh7FFF;
      quat[REG_QUAT_X] = '0;
      quat[REG_QUAT_Y] = '0;
      quat[REG_QUAT_Z] = '0;
      errors = 0;
      checked = 0;
      clipped_seen = 0;
      rebuild();
    endfunction

    // add half an lsb, then floor
    function longint round_half_up(longint v);
      return (v + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function logic signed [MAT_W-1:0] entry(longint exact);
      longint r;
      longint lim;
      r = round_half_up(exact);
      lim = longint'(1) <<< (MAT_W - 1);
      if (r >= lim) r = lim - 1;
      else if (r < -lim) r = -lim;
      return r[MAT_W-1:0];
    endfunction

    // column-major: entry 3*c+r is row r of column c
    function void rebuild();
      longint w, x, y, z, one;
      w = longint'(quat[REG_QUAT_W]);
      x = longint'(quat[REG_QUAT_X]);
      y = longint'(quat[REG_QUAT_Y]);
      z = longint'(quat[REG_QUAT_Z]);
      one = longint'(1) <<< (2 * FRAC);
      matrix[0] = entry(one - 2 * (y * y + z * z));
      matrix[1] = entry(2 * (x * y + z * w));
      matrix[2] = entry(2 * (x * z - y * w));
      matrix[3] = entry(2 * (x * y - z * w));
      matrix[4] = entry(one - 2 * (x * x + z * z));
      matrix[5] = entry(2 * (y * z + x * w));
      matrix[6] = entry(2 * (x * z + y * w));
      matrix[7] = entry(2 * (y * z - x * w));
      matrix[8] = entry(one - 2 * (x * x + y * y));
    endfunction

    function void write_reg(cfg_wr_t wr);
      quat[wr.index] = wr.value;
      rebuild();
    endfunction

    function void note_vector(vec_t v);
      rot_t   r;
      longint comp [3];
      longint acc;
      logic   hit;
      int     i;
      hit = 1'b0;
      for (i = 0; i < 3; i++) begin
        acc = longint'(matrix[i]) * longint'($signed(v.vec_x))
            + longint'(matrix[3 + i]) * longint'($signed(v.vec_y))
            + longint'(matrix[6 + i]) * longint'($signed(v.vec_z));
        acc = round_half_up(acc);
        if (acc > 32767) begin
          acc = 32767;
          hit = 1'b1;
        end else if (acc < -32768) begin
          acc = -32768;
          hit = 1'b1;
        end
        comp[i] = acc;
      end
      r.rot_x = comp[0][15:0];
      r.rot_y = comp[1][15:0];
      r.rot_z = comp[2][15:0];
      r.clipped = hit;
      expected_rots.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_rotation(rot_t got);
      rot_t want;
      if (expected_rots.size() == 0) begin
        report($sformatf("result (%0d,%0d,%0d) clipped=%0b with none expected",
                         $signed(got.rot_x), $signed(got.rot_y), $signed(got.rot_z),
                         got.clipped));
        return;
      end
      want = expected_rots.pop_front();
      if (want.clipped) clipped_seen++;
      if (got.rot_x !== want.rot_x)
        report($sformatf("result %0d rot_x got %0d want %0d", checked,
                         $signed(got.rot_x), $signed(want.rot_x)));
      if (got.rot_y !== want.rot_y)
        report($sformatf("result %0d rot_y got %0d want %0d", checked,
                         $signed(got.rot_y), $signed(want.rot_y)));
      if (got.rot_z !== want.rot_z)
        report($sformatf("result %0d rot_z got %0d want %0d", checked,
                         $signed(got.rot_z), $signed(want.rot_z)));
      if (got.clipped !== want.clipped)
        report($sformatf("result %0d clipped got %0b want %0b", checked,
                         got.clipped, want.clipped));
      checked++;
    endtask

    function int pending();
      return expected_rots.size();
    endfunction

    task flag_leftovers();
      if (expected_rots.size() != 0)
        report($sformatf("%0d rotated vectors never came out", expected_rots.size()));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        sink_ready = 1'b0;
  int unsigned cycles = 0;
  int          hold_cnt = 0;
  bit          steady = 1'b0;
  int          vectors_sent = 0;
  int          quat_settings = 0;

  qvr_stream_if #(.T(cfg_wr_t)) cfg_if ();
  qvr_stream_if #(.T(vec_t))    vec_if ();
  qvr_stream_if #(.T(rot_t))    rot_if ();

  rotation_board board;

  quaternion_vector_rotation #(.QUAT_FRAC_BITS(FRAC_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_if),
    .vec(vec_if),
    .rot(rot_if)
  );

  assign rot_if.ready = sink_ready;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d results outstanding",
               cycles, board.pending());
      $display("** quaternion_vector_rotation: FAILED **");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 10);
    else return $urandom_range(20, 50);
  endfunction

  function automatic logic [15:0] extreme16();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'h0001;
      default: return 16'h4000;
    endcase
  endfunction

  function automatic vec_t pick_vec();
    vec_t v;
    int   mode;
    mode = $urandom_range(0, 9);
    if (mode < 7) begin
      v.vec_x = 16'($urandom);
      v.vec_y = 16'($urandom);
      v.vec_z = 16'($urandom);
    end else if (mode < 9) begin
      v.vec_x = 16'($urandom_range(0, 600) - 300);
      v.vec_y = 16'($urandom_range(0, 600) - 300);
      v.vec_z = 16'($urandom_range(0, 600) - 300);
    end else begin
      v.vec_x = extreme16();
      v.vec_y = extreme16();
      v.vec_z = extreme16();
    end
    return v;
  endfunction

  function automatic quat4_t pick_quat();
    quat4_t q;
    real    a [4];
    real    norm;
    int     mode;
    int     i;
    mode = $urandom_range(0, 9);
    if (mode < 5) begin
      // unit quaternion, so results mostly stay in range
      norm = 0.0;
      for (i = 0; i < 4; i++) begin
        a[i] = real'($urandom_range(0, 65535)) - 32768.0;
        norm = norm + a[i] * a[i];
      end
      norm = $sqrt(norm);
      for (i = 0; i < 4; i++)
        q[i] = (norm < 1.0) ? ((i == 0) ? 16'sh7FFF : 16'sh0000)
                            : 16'($rtoi(a[i] * 32767.0 / norm));
    end else begin
      for (i = 0; i < 4; i++) begin
        if (mode < 7) q[i] = 16'($urandom);
        else if (mode < 8) q[i] = extreme16();
        else q[i] = 16'($urandom_range(0, 512) - 256);
      end
    end
    return q;
  endfunction

  task automatic send_vec(vec_t v);
    int g;
    g = steady ? 0 : pick_gap();
    if (g != 0) begin
      vec_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    vec_if.valid <= 1'b1;
    vec_if.data <= v;
    do @(posedge clk); while (!(vec_if.valid && vec_if.ready));
    vectors_sent++;
  endtask

  // bit i of mask selects register index i; only issued once the block has drained
  task automatic write_quat(logic [3:0] mask, quat4_t q);
    cfg_wr_t wr;
    int      i;
    vec_if.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    for (i = 0; i < 4; i++) begin
      if (mask[i]) begin
        wr.index = cfg_reg_t'(i);
        wr.value = q[i];
        cfg_if.valid <= 1'b1;
        cfg_if.data <= wr;
        do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
      end
    end
    cfg_if.valid <= 1'b0;
    quat_settings++;
  endtask

  // output stalls
  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      sink_ready <= 1'b0;
      hold_cnt <= pick_gap();
    end else begin
      sink_ready <= 1'b1;
      hold_cnt <= $urandom_range(0, 6);
    end
  end

  // transfer monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) board.write_reg(cfg_if.data);
      if (vec_if.valid && vec_if.ready) board.note_vector(vec_if.data);
      if (rot_if.valid && rot_if.ready) board.check_rotation(rot_if.data);
    end
  end

  initial begin
    int n;
    int i;
    int target;
    board = new();
    rst <= 1'b1;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    vec_if.valid <= 1'b0;
    vec_if.data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset quaternion gives identity
    send_vec('{16'h0000, 16'h0000, 16'h0000});
    send_vec('{16'h7FFF, 16'h8000, 16'h0001});
    send_vec('{16'h8000, 16'h7FFF, 16'hFFFF});
    send_vec('{16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_vec('{16'h5555, 16'hAAAA, 16'h0000});

    // non-unit quaternion: matrix entries saturate and results clip
    write_quat(4'hF, '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    send_vec('{16'h7FFF, 16'h7FFF, 16'h7FFF});
    send_vec('{16'h8000, 16'h8000, 16'h8000});
    send_vec('{16'h0001, 16'h0000, 16'h0000});
    send_vec('{16'h0000, 16'h0001, 16'hFFFF});

    // quarter turn about z
    write_quat(4'hF, '{16'sd23170, 16'sd0, 16'sd0, 16'sd23170});
    send_vec('{16'd1000, 16'd0, 16'd0});
    send_vec('{16'd0, -16'sd1000, 16'd500});
    send_vec('{16'h7FFF, 16'h7FFF, 16'h0000});

    // half turn about x, y stays zero
    write_quat(4'b1011, '{16'sd0, 16'sh7FFF, 16'sd0, 16'sd0});
    send_vec('{16'd100, 16'd200, 16'd300});
    send_vec('{16'h8000, 16'h8000, 16'h8000});

    write_quat(4'hF, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
    send_vec('{16'h7FFF, 16'h8000, 16'd12345});
    send_vec('{16'hFFFF, 16'h0001, 16'h0000});

    n = 0;
    while (n < RAND_ITEMS) begin
      write_quat(($urandom_range(0, 4) == 0) ? 4'($urandom_range(1, 15)) : 4'hF,
                 pick_quat());
      steady = ($urandom_range(0, 4) == 0);
      target = $urandom_range(40, 160);
      for (i = 0; i < target && n < RAND_ITEMS; i++) begin
        send_vec(pick_vec());
        n++;
      end
    end

    vec_if.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    board.flag_leftovers();

    $display("rotated %0d vectors under %0d quaternion settings", vectors_sent,
             quat_settings);
    $display("%0d results compared, %0d of them saturated, %0d mismatches",
             board.checked, board.clipped_seen, board.errors);
    if (board.errors == 0) begin
      $display("** quaternion_vector_rotation: PASSED **");
    end else begin
      $display("** quaternion_vector_rotation: FAILED **");
    end
    $finish;
  end
endmodule

### files.f
+incdir+hdl
hdl/qvr_pkg.sv
hdl/qvr_stream_if.sv
hdl/qvr_matrix.sv
hdl/quaternion_vector_rotation.sv
tb/quaternion_vector_rotation_tb.sv
